### sv/gbrt_pkg.sv
// Package: field widths, action codes and shared types of the grouped best-rated table.
`timescale 1ns / 1ps
package gbrt_pkg;

    localparam int ACTION_W = 2;
    localparam int ID_W     = 10;
    localparam int GROUP_W  = 6;
    localparam int RATING_W = 27;
    localparam int KEY_W    = 50;

    localparam logic [ACTION_W-1:0] ACT_ADD    = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_CHANGE = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_QUERY  = 2'd2;

    // control from the sequencer to the scan unit
    typedef struct packed {
        logic clr;
        logic step;
    } t_scan_ctl;

endpackage

### sv/gbrt_if.sv
// Interfaces: request channel and result channel, valid/ready with payload.
`timescale 1ns / 1ps
interface gbrt_in_if;
    import gbrt_pkg::*;

    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic [ID_W-1:0]     item_id;
    logic [GROUP_W-1:0]  group_id;
    logic [RATING_W-1:0] rating;
    logic [KEY_W-1:0]    name_key;

    modport source (output valid, action, item_id, group_id, rating, name_key,
                    input ready);
    modport sink   (input valid, action, item_id, group_id, rating, name_key,
                    output ready);
endinterface

interface gbrt_res_if;
    import gbrt_pkg::*;

    logic                valid;
    logic                ready;
    logic                found;
    logic [ID_W-1:0]     best_id;
    logic [KEY_W-1:0]    best_name_key;
    logic [RATING_W-1:0] best_rating;

    modport source (output valid, found, best_id, best_name_key, best_rating,
                    input ready);
    modport sink   (input valid, found, best_id, best_name_key, best_rating,
                    output ready);
endinterface

### sv/grouped_best_rated_table.sv
// Top level: sequencer, entry store and scan unit of the grouped best-rated table.
`timescale 1ns / 1ps
// Table of MAX_ITEMS entries (group, rating, name key) indexed by item id. After reset
// the block clears every entry of the store and takes no request meanwhile. Then it
// handles one request at a time: an add is written from the idle state, a rating change
// reads the entry and then writes it back, and a query scans all MAX_ITEMS entries as
// the single read port delivers one entry per cycle to the compare stage. The result
// sits in an output register; a new request is taken while it waits to be collected.
module grouped_best_rated_table #(
    parameter int MAX_ITEMS  = 1024,
    parameter int MAX_GROUPS = 64,
    parameter int NAME_CHARS = 10
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    gbrt_in_if.sink           i_in,
    gbrt_res_if.source        o_res
);
    import gbrt_pkg::*;

    localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int NB = 5 * NAME_CHARS;
    localparam int KW = (NB < KEY_W) ? NB : KEY_W;
    localparam int DW = 1 + GROUP_W + RATING_W + KW;
    localparam logic [AW-1:0] LAST = AW'(MAX_ITEMS - 1);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_CHG_RD,
        S_CHG_WR,
        S_SCAN,
        S_DRAIN,
        S_DONE
    } t_state;

    t_state              r_state;
    logic [AW-1:0]       r_addr;
    logic [AW-1:0]       r_pidx;
    logic                r_pend;
    logic [GROUP_W-1:0]  r_grp;
    logic [RATING_W-1:0] r_rating;
    logic                r_ovalid;
    logic                r_found;
    logic [ID_W-1:0]     r_best_id;
    logic [KEY_W-1:0]    r_best_key;
    logic [RATING_W-1:0] r_best_rating;

    logic                w_accept;
    logic                w_id_ok;
    logic                w_grp_ok;
    logic                w_we;
    logic [AW-1:0]       w_waddr;
    logic [DW-1:0]       w_wdata;
    logic [DW-1:0]       w_rdata;
    logic                w_ent_valid;
    logic [GROUP_W-1:0]  w_ent_group;
    logic [RATING_W-1:0] w_ent_rating;
    logic [KW-1:0]       w_ent_key;
    t_scan_ctl           w_ctl;
    logic                w_have;
    logic [AW-1:0]       w_best_idx;
    logic [RATING_W-1:0] w_scan_rating;
    logic [KW-1:0]       w_scan_key;

    assign i_in.ready = (r_state == S_IDLE);
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_id_ok    = 32'(i_in.item_id) < MAX_ITEMS;
    assign w_grp_ok   = 32'(i_in.group_id) < MAX_GROUPS;

    assign w_ent_valid  = w_rdata[DW-1];
    assign w_ent_group  = w_rdata[DW-2 -: GROUP_W];
    assign w_ent_rating = w_rdata[KW +: RATING_W];
    assign w_ent_key    = w_rdata[KW-1:0];

    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_addr;
        w_wdata = '0;
        case (r_state)
            S_CLEAR: begin
                w_we = 1'b1;
            end
            S_IDLE: begin
                w_we    = w_accept && (i_in.action == ACT_ADD) && w_id_ok && w_grp_ok;
                w_waddr = AW'(i_in.item_id);
                w_wdata = {1'b1, i_in.group_id, i_in.rating, KW'(i_in.name_key)};
            end
            S_CHG_WR: begin
                // change applies only to a stored entry
                w_we    = w_ent_valid;
                w_wdata = {w_rdata[DW-1 -: 1 + GROUP_W], r_rating, w_ent_key};
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
    end

    assign w_ctl.clr  = w_accept && (i_in.action == ACT_QUERY);
    assign w_ctl.step = r_pend;

    gbrt_mem #(
        .DEPTH (MAX_ITEMS),
        .AW    (AW),
        .DW    (DW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (r_addr),
        .o_rdata (w_rdata)
    );

    gbrt_scan #(
        .AW (AW),
        .KW (KW)
    ) u_scan (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (w_ctl),
        .i_qgroup      (r_grp),
        .i_ent_valid   (w_ent_valid),
        .i_ent_group   (w_ent_group),
        .i_ent_rating  (w_ent_rating),
        .i_ent_key     (w_ent_key),
        .i_ent_idx     (r_pidx),
        .o_have        (w_have),
        .o_best_idx    (w_best_idx),
        .o_best_rating (w_scan_rating),
        .o_best_key    (w_scan_key)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_addr   <= '0;
            r_pend   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_pend <= (r_state == S_SCAN);
            r_pidx <= r_addr;
            // S_DONE reloads the output register on its own
            if (r_ovalid && o_res.ready && (r_state != S_DONE)) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    if (r_addr == LAST) begin
                        r_addr  <= '0;
                        r_state <= S_IDLE;
                    end else begin
                        r_addr <= r_addr + AW'(1);
                    end
                end
                S_IDLE: begin
                    if (w_accept) begin
                        r_grp    <= i_in.group_id;
                        r_rating <= i_in.rating;
                        if (i_in.action == ACT_QUERY) begin
                            r_addr  <= '0;
                            r_state <= S_SCAN;
                        end else if ((i_in.action == ACT_CHANGE) && w_id_ok) begin
                            r_addr  <= AW'(i_in.item_id);
                            r_state <= S_CHG_RD;
                        end
                    end
                end
                S_CHG_RD: begin
                    r_state <= S_CHG_WR;
                end
                S_CHG_WR: begin
                    r_state <= S_IDLE;
                end
                S_SCAN: begin
                    r_addr <= r_addr + AW'(1);
                    if (r_addr == LAST) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (!r_ovalid || o_res.ready) begin
                        r_ovalid      <= 1'b1;
                        r_found       <= w_have;
                        r_best_id     <= w_have ? ID_W'(w_best_idx) : '0;
                        r_best_key    <= w_have ? KEY_W'(w_scan_key) : '0;
                        r_best_rating <= w_have ? w_scan_rating : '0;
                        r_state       <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_res.valid         = r_ovalid;
    assign o_res.found         = r_found;
    assign o_res.best_id       = r_best_id;
    assign o_res.best_name_key = r_best_key;
    assign o_res.best_rating   = r_best_rating;

`ifndef SYNTHESIS
    a_no_req_in_clear: assert property (@(posedge i_clk)
        (r_state == S_CLEAR) |-> !i_in.ready)
        else $error("request taken during store clear");

    a_no_write_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN || r_state == S_DRAIN) |-> !w_we)
        else $error("store written during query scan");

    a_query_starts_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_in.action == ACT_QUERY) |=> (r_state == S_SCAN))
        else $error("query beat did not start a scan");

    a_empty_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && !o_res.found) |->
        (o_res.best_rating == '0 && o_res.best_id == '0 && o_res.best_name_key == '0))
        else $error("empty-group result carries nonzero fields");
`endif

endmodule

### sv/gbrt_mem.sv
// Entry store: one write port, one read port with registered read data.
`timescale 1ns / 1ps
module gbrt_mem #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10,
    parameter int DW    = 84
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### sv/gbrt_scan.sv
// Scan unit: keeps the best entry of the queried group while the table streams past.
`timescale 1ns / 1ps
module gbrt_scan #(
    parameter int AW = 10,
    parameter int KW = 50
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  gbrt_pkg::t_scan_ctl           i_ctl,
    input  logic [gbrt_pkg::GROUP_W-1:0]  i_qgroup,
    input  logic                          i_ent_valid,
    input  logic [gbrt_pkg::GROUP_W-1:0]  i_ent_group,
    input  logic [gbrt_pkg::RATING_W-1:0] i_ent_rating,
    input  logic [KW-1:0]                 i_ent_key,
    input  logic [AW-1:0]                 i_ent_idx,
    output logic                          o_have,
    output logic [AW-1:0]                 o_best_idx,
    output logic [gbrt_pkg::RATING_W-1:0] o_best_rating,
    output logic [KW-1:0]                 o_best_key
);
    import gbrt_pkg::*;

    logic                r_have;
    logic [AW-1:0]       r_best_idx;
    logic [RATING_W-1:0] r_best_rating;
    logic [KW-1:0]       r_best_key;
    logic                w_take;

    // strict improvement only: entries arrive in ascending id, so full ties keep the first
    always_comb begin
        w_take = i_ctl.step && i_ent_valid && (i_ent_group == i_qgroup) &&
                 (!r_have || (i_ent_rating > r_best_rating) ||
                  ((i_ent_rating == r_best_rating) && (i_ent_key < r_best_key)));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have <= 1'b0;
        end else if (i_ctl.clr) begin
            r_have <= 1'b0;
        end else if (w_take) begin
            r_have <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_best_idx    <= i_ent_idx;
            r_best_rating <= i_ent_rating;
            r_best_key    <= i_ent_key;
        end
    end

    assign o_have        = r_have;
    assign o_best_idx    = r_best_idx;
    assign o_best_rating = r_best_rating;
    assign o_best_key    = r_best_key;

endmodule
